// File: hdl/dat_pkg.sv
package dat_pkg;

  localparam int TABLE_DEPTH_DEF = 65536;
  localparam int KEY_LENGTH_MAX = 4095;

  localparam logic [1:0] OP_WRITE = 2'd0;
  localparam logic [1:0] OP_BYTE = 2'd1;
  localparam logic [1:0] OP_FINISH = 2'd2;

  localparam logic [1:0] ST_FOUND = 2'd0;
  localparam logic [1:0] ST_NOMATCH = 2'd1;
  localparam logic [1:0] ST_TOOLONG = 2'd2;

  localparam logic REG_SEARCH_MODE = 1'b0;
  localparam logic REG_MAX_KEY_LENGTH = 1'b1;

  typedef struct packed {
    logic        search_mode;
    logic [11:0] limit;
  } dat_cfg_t;

  function automatic logic [29:0] unit_offset(input logic [31:0] u);
    unit_offset = u[9] ? {u[31:10], 8'd0} : {8'd0, u[31:10]};
  endfunction

endpackage

// File: hdl/dat_unit_ram.sv
module dat_unit_ram
  import dat_pkg::*;
#(
  parameter int TABLE_DEPTH = TABLE_DEPTH_DEF,
  localparam int AW = $clog2(TABLE_DEPTH)
) (
  input  logic          clk,
  input  logic          en,
  input  logic          we,
  input  logic [AW-1:0] addr,
  input  logic [31:0]   wdata,
  output logic [31:0]   rdata
);

  logic [31:0] mem [TABLE_DEPTH];

  always_ff @(posedge clk) begin
    if (en) begin
      if (we) begin
        mem[addr] <= wdata;
      end else begin
        rdata <= mem[addr];
      end
    end
  end

endmodule

// File: hdl/dat_walker.sv
module dat_walker
  import dat_pkg::*;
#(
  parameter int TABLE_DEPTH = TABLE_DEPTH_DEF,
  localparam int AW = $clog2(TABLE_DEPTH)
) (
  input  logic          clk,
  input  logic          rst,
  input  dat_cfg_t      cfg,
  input  logic          in_valid,
  output logic          in_ready,
  input  logic [1:0]    opcode,
  input  logic [15:0]   unit_index,
  input  logic [31:0]   unit_word,
  input  logic [7:0]    key_byte,
  output logic          out_valid,
  input  logic          out_ready,
  output logic [1:0]    status,
  output logic [30:0]   match_value,
  output logic [11:0]   match_length,
  output logic          ram_en,
  output logic          ram_we,
  output logic [AW-1:0] ram_addr,
  output logic [31:0]   ram_wdata,
  input  logic [31:0]   ram_rdata
);

  localparam logic [31:0] DEPTH_W = 32'(TABLE_DEPTH);

  typedef enum logic [6:0] {
    S_IDLE   = 7'b0000001,
    S_STEP   = 7'b0000010,
    S_CHILD  = 7'b0000100,
    S_LEAF   = 7'b0001000,
    S_FCUR   = 7'b0010000,
    S_FLEAF  = 7'b0100000,
    S_REPORT = 7'b1000000
  } state_t;

  state_t        state;
  logic [AW-1:0] pos;
  logic [AW-1:0] nxt;
  logic [7:0]    byte_q;
  logic [12:0]   bytes_seen;
  logic          walk_failed;
  logic [30:0]   best_value;
  logic [11:0]   best_length;
  logic          best_found;
  logic [1:0]    res_status;
  logic [30:0]   res_value;
  logic [11:0]   res_length;

  logic          accept;
  logic [31:0]   uidx_ext;
  logic          uidx_ok;
  logic          walk_go;
  logic          too_long;
  logic [29:0]   base;
  logic [29:0]   jump;
  logic          jump_ok;
  logic          label_ok;
  logic          leaf;

  assign in_ready = (state == S_IDLE);
  assign accept = in_valid && in_ready;
  assign uidx_ext = {16'd0, unit_index};
  assign uidx_ok = uidx_ext < DEPTH_W;
  assign walk_go = (bytes_seen < {1'b0, cfg.limit}) && !walk_failed;
  assign too_long = bytes_seen > {1'b0, cfg.limit};
  assign base = (state == S_CHILD) ? 30'(nxt) : 30'(pos);
  assign jump = base ^ unit_offset(ram_rdata) ^ ((state == S_STEP) ? {22'd0, byte_q} : 30'd0);
  assign jump_ok = {2'd0, jump} < DEPTH_W;
  assign label_ok = !ram_rdata[31] && (ram_rdata[7:0] == byte_q);
  assign leaf = ram_rdata[8];

  always_comb begin
    ram_en = 1'b0;
    ram_we = 1'b0;
    ram_addr = pos;
    ram_wdata = unit_word;
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          case (opcode)
            OP_WRITE: begin
              ram_en = uidx_ok;
              ram_we = 1'b1;
              ram_addr = uidx_ext[AW-1:0];
            end
            OP_BYTE: begin
              ram_en = walk_go;
            end
            OP_FINISH: begin
              ram_en = !cfg.search_mode && !too_long && !walk_failed;
            end
            default: begin
              ram_en = 1'b0;
            end
          endcase
        end
      end
      S_STEP: begin
        ram_en = jump_ok;
        ram_addr = jump[AW-1:0];
      end
      S_CHILD: begin
        ram_en = label_ok && leaf && jump_ok;
        ram_addr = jump[AW-1:0];
      end
      S_FCUR: begin
        ram_en = leaf && jump_ok;
        ram_addr = jump[AW-1:0];
      end
      default: begin
        ram_en = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      pos <= '0;
      bytes_seen <= '0;
      walk_failed <= 1'b0;
      best_value <= '0;
      best_length <= '0;
      best_found <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (state == S_REPORT && (!out_valid || out_ready)) begin
        out_valid <= 1'b1;
        status <= res_status;
        match_value <= res_value;
        match_length <= res_length;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end

      unique case (state)
        S_IDLE: begin
          if (accept && opcode == OP_BYTE) begin
            byte_q <= key_byte;
            if (walk_go) begin
              state <= S_STEP;
            end
            if (!too_long) begin
              bytes_seen <= bytes_seen + 13'd1;
            end
          end else if (accept && opcode == OP_FINISH) begin
            res_status <= ST_NOMATCH;
            res_value <= '0;
            res_length <= '0;
            if (!cfg.search_mode && !too_long && !walk_failed) begin
              state <= S_FCUR;
            end else begin
              state <= S_REPORT;
              if (!cfg.search_mode && too_long) begin
                res_status <= ST_TOOLONG;
              end else if (cfg.search_mode && best_found) begin
                res_status <= ST_FOUND;
                res_value <= best_value;
                res_length <= best_length;
              end
              pos <= '0;
              bytes_seen <= '0;
              walk_failed <= 1'b0;
              best_value <= '0;
              best_length <= '0;
              best_found <= 1'b0;
            end
          end
        end
        S_STEP: begin
          nxt <= jump[AW-1:0];
          if (jump_ok) begin
            state <= S_CHILD;
          end else begin
            walk_failed <= 1'b1;
            state <= S_IDLE;
          end
        end
        S_CHILD: begin
          if (!label_ok) begin
            walk_failed <= 1'b1;
            state <= S_IDLE;
          end else begin
            pos <= nxt;
            state <= (leaf && jump_ok) ? S_LEAF : S_IDLE;
          end
        end
        S_LEAF: begin
          best_value <= ram_rdata[30:0];
          best_length <= bytes_seen[11:0];
          best_found <= 1'b1;
          state <= S_IDLE;
        end
        S_FCUR: begin
          if (leaf && jump_ok) begin
            state <= S_FLEAF;
          end else begin
            state <= S_REPORT;
            pos <= '0;
            bytes_seen <= '0;
            walk_failed <= 1'b0;
            best_value <= '0;
            best_length <= '0;
            best_found <= 1'b0;
          end
        end
        S_FLEAF: begin
          res_status <= ST_FOUND;
          res_value <= ram_rdata[30:0];
          res_length <= bytes_seen[11:0];
          state <= S_REPORT;
          pos <= '0;
          bytes_seen <= '0;
          walk_failed <= 1'b0;
          best_value <= '0;
          best_length <= '0;
          best_found <= 1'b0;
        end
        S_REPORT: begin
          if (!out_valid || out_ready) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

// File: hdl/double_array_trie_lookup.sv
// A key byte needs no read once the walk has stopped or the limit is reached; else it
// makes one dependent read of the unit memory each for the current unit, the child unit
// and the leaf unit, as far as the walk gets. A finish in exact mode on a live walk reads
// the current unit and, for a leaf, the leaf unit. The result then loads the output
// register unless a waiting result holds it back; the next request is taken once it is in.
// Synchronous reset clears the walk, the output and the registers; the unit table is kept.
module double_array_trie_lookup
  import dat_pkg::*;
#(
  parameter int TABLE_DEPTH = TABLE_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  opcode,
  input  logic [15:0] unit_index,
  input  logic [31:0] unit_word,
  input  logic [7:0]  key_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  status,
  output logic [30:0] match_value,
  output logic [11:0] match_length
);

  localparam int AW = $clog2(TABLE_DEPTH);
  localparam logic [15:0] KEY_MAX = 16'(KEY_LENGTH_MAX);

  logic          search_mode;
  logic [11:0]   max_key_length;
  dat_cfg_t      cfg;
  logic          ram_en;
  logic          ram_we;
  logic [AW-1:0] ram_addr;
  logic [31:0]   ram_wdata;
  logic [31:0]   ram_rdata;

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      search_mode <= 1'b0;
      max_key_length <= 12'd4095;
    end else if (psel && penable && pwrite && pready) begin
      unique case (paddr[2])
        REG_SEARCH_MODE: search_mode <= pwdata[0];
        REG_MAX_KEY_LENGTH: max_key_length <= pwdata[11:0];
        default: search_mode <= search_mode;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      REG_SEARCH_MODE: prdata = {31'd0, search_mode};
      REG_MAX_KEY_LENGTH: prdata = {20'd0, max_key_length};
      default: prdata = '0;
    endcase
  end

  assign cfg.search_mode = search_mode;
  assign cfg.limit = (KEY_MAX < {4'd0, max_key_length}) ? KEY_MAX[11:0] : max_key_length;

  dat_unit_ram #(
    .TABLE_DEPTH(TABLE_DEPTH)
  ) u_ram (
    .clk  (clk),
    .en   (ram_en),
    .we   (ram_we),
    .addr (ram_addr),
    .wdata(ram_wdata),
    .rdata(ram_rdata)
  );

  dat_walker #(
    .TABLE_DEPTH(TABLE_DEPTH)
  ) u_walker (
    .clk         (clk),
    .rst         (rst),
    .cfg         (cfg),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .opcode      (opcode),
    .unit_index  (unit_index),
    .unit_word   (unit_word),
    .key_byte    (key_byte),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .status      (status),
    .match_value (match_value),
    .match_length(match_length),
    .ram_en      (ram_en),
    .ram_we      (ram_we),
    .ram_addr    (ram_addr),
    .ram_wdata   (ram_wdata),
    .ram_rdata   (ram_rdata)
  );

`ifndef SYNTHESIS
  a_finish_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && opcode == OP_FINISH |=> !in_ready)
    else $error("block took a request right after a finish request");

  a_write_one_cycle: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && opcode == OP_WRITE |=> in_ready)
    else $error("unit write did not complete in one cycle");

  a_miss_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && status != ST_FOUND |-> match_value == 31'd0 && match_length == 12'd0)
    else $error("result without a match carries a value or length");

  a_reset_out: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result present after reset");
`endif

endmodule

// File: test/double_array_trie_lookup_check.sv
`timescale 1ns / 100ps
module double_array_trie_lookup_check
  import dat_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  input  logic        pready,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic [1:0]  opcode,
  input  logic [15:0] unit_index,
  input  logic [31:0] unit_word,
  input  logic [7:0]  key_byte,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic [1:0]  status,
  input  logic [30:0] match_value,
  input  logic [11:0] match_length,
  output int          failures,
  output int          pending
);

  typedef struct packed {
    logic [1:0]  status;
    logic [30:0] value;
    logic [11:0] length;
  } lookup_result_t;

  logic [31:0]    units [TABLE_DEPTH_DEF];
  lookup_result_t expected_lookups [$];

  logic [29:0] walk_pos;
  logic [12:0] seen;
  logic        walk_dead;
  logic [30:0] best_value;
  logic [11:0] best_length;
  logic        best_hit;
  logic        prefix_mode;
  logic [11:0] max_len;

  function automatic logic [29:0] hop_offset(input logic [31:0] u);
    logic [29:0] o;
    o = 30'(u[31:10]);
    if (u[9]) o = o << 8;
    return o;
  endfunction

  function automatic logic leaf_at(input logic [29:0] pos, output logic [30:0] value);
    logic [29:0] idx;
    value = '0;
    if (pos >= TABLE_DEPTH_DEF || !units[pos][8]) return 1'b0;
    idx = pos ^ hop_offset(units[pos]);
    if (idx >= TABLE_DEPTH_DEF) return 1'b0;
    value = units[idx][30:0];
    return 1'b1;
  endfunction

  task automatic restart_walk();
    walk_pos = '0;
    seen = '0;
    walk_dead = 1'b0;
    best_value = '0;
    best_length = '0;
    best_hit = 1'b0;
  endtask

  task automatic write_register();
    if (paddr == {REG_SEARCH_MODE, 2'b00}) prefix_mode = pwdata[0];
    else if (paddr == {REG_MAX_KEY_LENGTH, 2'b00}) max_len = pwdata[11:0];
  endtask

  task automatic take_request();
    logic [11:0]    lim;
    logic [29:0]    nxt;
    logic [30:0]    leaf_value;
    lookup_result_t res;
    lim = (max_len > KEY_LENGTH_MAX) ? 12'(KEY_LENGTH_MAX) : max_len;
    case (opcode)
      OP_WRITE: begin
        units[unit_index] = unit_word;
      end
      OP_BYTE: begin
        if (seen < lim && !walk_dead) begin
          nxt = walk_pos ^ hop_offset(units[walk_pos]) ^ 30'(key_byte);
          if (nxt >= TABLE_DEPTH_DEF || units[nxt][31] || units[nxt][7:0] != key_byte) begin
            walk_dead = 1'b1;
          end else begin
            walk_pos = nxt;
            if (leaf_at(nxt, leaf_value)) begin
              best_value = leaf_value;
              best_length = seen[11:0] + 12'd1;
              best_hit = 1'b1;
            end
          end
        end
        if (seen <= lim) seen = seen + 13'd1;
      end
      OP_FINISH: begin
        res.status = ST_NOMATCH;
        res.value = '0;
        res.length = '0;
        if (!prefix_mode) begin
          if (seen > lim) begin
            res.status = ST_TOOLONG;
          end else if (!walk_dead && leaf_at(walk_pos, leaf_value)) begin
            res.status = ST_FOUND;
            res.value = leaf_value;
            res.length = seen[11:0];
          end
        end else if (best_hit) begin
          res.status = ST_FOUND;
          res.value = best_value;
          res.length = best_length;
        end
        expected_lookups.push_back(res);
        restart_walk();
      end
      default: begin
      end
    endcase
  endtask

  task automatic check_result();
    lookup_result_t want;
    if (expected_lookups.size() == 0) begin
      $error("unexpected result: status %0d, match_value %0d, match_length %0d",
             status, match_value, match_length);
      failures++;
      return;
    end
    want = expected_lookups.pop_front();
    if (status !== want.status) begin
      $error("status: expected %0d, got %0d", want.status, status);
      failures++;
    end
    if (match_value !== want.value) begin
      $error("match_value: expected %0d, got %0d", want.value, match_value);
      failures++;
    end
    if (match_length !== want.length) begin
      $error("match_length: expected %0d, got %0d", want.length, match_length);
      failures++;
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      restart_walk();
      prefix_mode = 1'b0;
      max_len = 12'd4095;
      expected_lookups.delete();
    end else begin
      if (out_valid && out_ready) check_result();
      if (psel && penable && pwrite && pready) write_register();
      if (in_valid && in_ready) take_request();
    end
    pending = expected_lookups.size();
  end

endmodule

// File: test/double_array_trie_lookup_test.sv
`timescale 1ns / 100ps
module double_array_trie_lookup_test;
  import dat_pkg::*;

  localparam logic [1:0] OP_IGNORED = 2'd3;
  localparam int REGION = 512;
  localparam int SETTLE = 12;
  localparam int HOLD_CYCLES = 400;
  localparam int CYCLE_LIMIT = 500000;
  localparam int PHASES = 8;
  localparam int KEYS_PER_PHASE = 27;

  logic        clk;
  logic        rst;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;
  logic        in_valid;
  logic        in_ready;
  logic [1:0]  opcode;
  logic [15:0] unit_index;
  logic [31:0] unit_word;
  logic [7:0]  key_byte;
  logic        out_valid;
  logic        out_ready;
  logic [1:0]  status;
  logic [30:0] match_value;
  logic [11:0] match_length;

  int          failures;
  int          pending;
  int          cycles = 0;
  logic [7:0]  label_mask;
  logic        steady = 1'b0;
  logic        hold_armed = 1'b0;
  logic        hold_done = 1'b0;

  double_array_trie_lookup i_dut (
    .clk(clk), .rst(rst),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata),
    .prdata(prdata), .pready(pready),
    .in_valid(in_valid), .in_ready(in_ready), .opcode(opcode), .unit_index(unit_index),
    .unit_word(unit_word), .key_byte(key_byte),
    .out_valid(out_valid), .out_ready(out_ready), .status(status),
    .match_value(match_value), .match_length(match_length)
  );

  double_array_trie_lookup_check i_check (
    .clk(clk), .rst(rst),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata),
    .pready(pready),
    .in_valid(in_valid), .in_ready(in_ready), .opcode(opcode), .unit_index(unit_index),
    .unit_word(unit_word), .key_byte(key_byte),
    .out_valid(out_valid), .out_ready(out_ready), .status(status),
    .match_value(match_value), .match_length(match_length),
    .failures(failures), .pending(pending)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  always @(posedge clk) cycles <= cycles + 1;

  initial begin
    wait (cycles == CYCLE_LIMIT);
    $display("FAILURE");
    $finish;
  end

  // Every unit keeps the walk inside the first REGION entries or sends it past the
  // end of the table, so no unwritten entry is ever read. Most units carry a label
  // and an offset that let any next byte match.
  function automatic logic [31:0] make_unit(input logic [8:0] pos);
    logic [31:0] u;
    int          pick;
    pick = $urandom_range(0, 99);
    u = $urandom;
    if (pick < 70) begin
      u[31:19] = '0;
      u[17:10] = pos[7:0] ^ label_mask;
      u[9] = 1'b0;
      u[7:0] = pos[7:0] ^ label_mask;
    end else if (pick < 76) begin
      u[31:10] = 22'($urandom_range(0, 1));
      u[9] = 1'b1;
    end else if (pick < 86) begin
      u[31:19] = '0;
      u[9] = 1'b0;
    end else if (pick < 93) begin
      u[9] = 1'b0;
      if (u[31:26] == '0) u[26] = 1'b1;
    end else begin
      u[9] = 1'b1;
      if (u[31:18] == '0) u[18] = 1'b1;
    end
    return u;
  endfunction

  function automatic int idle_len();
    int pick;
    if (steady) return 0;
    pick = $urandom_range(0, 99);
    if (pick < 60) return 0;
    if (pick < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  task automatic send_request(input logic [1:0] op, input logic [15:0] idx,
                              input logic [31:0] word, input logic [7:0] kb);
    int gap;
    gap = idle_len();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    opcode <= op;
    unit_index <= idx;
    unit_word <= word;
    key_byte <= kb;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
  endtask

  task automatic send_byte(input logic [7:0] kb);
    send_request(OP_BYTE, 16'($urandom), $urandom, kb);
  endtask

  task automatic send_finish();
    send_request(OP_FINISH, 16'($urandom), $urandom, 8'($urandom));
  endtask

  task automatic rewrite_unit();
    logic [8:0] slot;
    slot = 9'($urandom_range(0, REGION - 1));
    send_request(OP_WRITE, 16'(slot), make_unit(slot), 8'($urandom));
  endtask

  task automatic set_reg(input logic index, input logic [11:0] value);
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {index, 2'b00};
    pwdata <= 32'(value);
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  task automatic run_key(input int lim, input bit close);
    int len;
    if ($urandom_range(0, 9) < 8) len = $urandom_range(0, 6);
    else len = (lim < 10) ? lim + $urandom_range(0, 2) : $urandom_range(7, 14);
    for (int b = 0; b < len; b++) begin
      if ($urandom_range(0, 49) == 0) send_request(OP_IGNORED, 16'($urandom), $urandom, 8'($urandom));
      if ($urandom_range(0, 39) == 0) rewrite_unit();
      send_byte(8'($urandom));
    end
    if (close) send_finish();
  endtask

  initial begin : result_drain
    int span;
    out_ready = 1'b0;
    @(negedge clk);
    forever begin
      if (hold_armed && !hold_done) begin
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_done = 1'b1;
      end
      out_ready <= 1'b1;
      repeat ($urandom_range(1, steady ? 60 : 12)) @(negedge clk);
      span = idle_len();
      if (span > 0) begin
        out_ready <= 1'b0;
        repeat (span) @(negedge clk);
      end
    end
  end

  initial begin : stimulus
    int limits [PHASES];
    int lim;
    rst = 1'b1;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    in_valid = 1'b0;
    opcode = OP_WRITE;
    unit_index = '0;
    unit_word = '0;
    key_byte = '0;
    label_mask = 8'($urandom);
    limits = '{4095, 3, 0, 1, 4095, 2, 4095, 6};
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    for (int p = 0; p < REGION; p++) begin
      send_request(OP_WRITE, 16'(p), make_unit(9'(p)), 8'($urandom));
    end

    send_finish();
    send_request(OP_IGNORED, 16'hFFFF, 32'hFFFF_FFFF, 8'hFF);
    send_request(OP_WRITE, 16'hFFFF, 32'hFFFF_FFFF, 8'hFF);
    send_request(OP_WRITE, 16'(REGION), 32'h0, 8'h00);
    send_byte(8'h00);
    send_byte(8'hFF);
    send_finish();
    set_reg(REG_SEARCH_MODE, 12'd1);
    send_finish();
    repeat (3) send_byte(8'($urandom));
    send_finish();
    set_reg(REG_MAX_KEY_LENGTH, 12'd2);
    set_reg(REG_SEARCH_MODE, 12'd0);
    repeat (4) send_byte(8'($urandom));
    send_finish();
    set_reg(REG_SEARCH_MODE, 12'd1);
    repeat (4) send_byte(8'($urandom));
    send_finish();
    set_reg(REG_MAX_KEY_LENGTH, 12'd0);
    set_reg(REG_SEARCH_MODE, 12'd0);
    send_finish();
    send_byte(8'($urandom));
    send_finish();

    for (int ph = 0; ph < PHASES; ph++) begin
      steady = (ph % 3 == 2);
      if (ph == 1) hold_armed = 1'b1;
      lim = (ph == 6) ? $urandom_range(7, 4095) : limits[ph];
      set_reg(REG_SEARCH_MODE, 12'($urandom_range(0, 1)));
      set_reg(REG_MAX_KEY_LENGTH, 12'(lim));
      repeat (16) rewrite_unit();
      repeat (3) send_request(OP_WRITE, 16'($urandom_range(REGION, 65535)), $urandom,
                              8'($urandom));
      for (int k = 0; k < KEYS_PER_PHASE; k++) begin
        run_key(lim, k < KEYS_PER_PHASE - 1 || $urandom_range(0, 2) != 0);
      end
    end
    send_finish();

    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
    if (failures == 0) $display("SUCCESS");
    else $display("FAILURE");
    $finish;
  end

endmodule
